FILE: rtl/core/assert_macros.svh
// assertion macros for the p-code core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// implication checked in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

FILE: rtl/core/psm_pkg.sv
// shared constants for the p-code stack machine
package psm_pkg;
  localparam int StackDepth = 1024;
  localparam int CodeDepth  = 1024;
  localparam int SaW = $clog2(StackDepth);
  localparam int PcW = $clog2(CodeDepth);
  localparam int TopW = SaW + 1;

  localparam logic [2:0] CMD_LIT = 3'd0;
  localparam logic [2:0] CMD_LOD = 3'd1;
  localparam logic [2:0] CMD_STO = 3'd2;
  localparam logic [2:0] CMD_CAL = 3'd3;
  localparam logic [2:0] CMD_INT = 3'd4;
  localparam logic [2:0] CMD_JMP = 3'd5;
  localparam logic [2:0] CMD_JPC = 3'd6;
  localparam logic [2:0] CMD_OPR = 3'd7;

  localparam logic [3:0] OPR_RET = 4'd0;
  localparam logic [3:0] OPR_NEG = 4'd1;
  localparam logic [3:0] OPR_ADD = 4'd2;
  localparam logic [3:0] OPR_SUB = 4'd3;
  localparam logic [3:0] OPR_MUL = 4'd4;
  localparam logic [3:0] OPR_DIV = 4'd5;
  localparam logic [3:0] OPR_EQ  = 4'd6;
  localparam logic [3:0] OPR_NE  = 4'd7;
  localparam logic [3:0] OPR_LT  = 4'd8;
  localparam logic [3:0] OPR_GE  = 4'd9;
  localparam logic [3:0] OPR_GT  = 4'd10;
  localparam logic [3:0] OPR_LE  = 4'd11;
  localparam logic [3:0] OPR_PRT = 4'd12;
  localparam logic [3:0] OPR_NL  = 4'd13;
  localparam logic [3:0] OPR_RD  = 4'd14;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_OPR   = 3'd2;
  localparam logic [2:0] ERR_RANGE = 3'd3;
  localparam logic [2:0] ERR_DIV   = 3'd4;
endpackage

FILE: rtl/core/psm_ram.sv
// generic single-port-write, single-port-read ram with registered read
module psm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/pcode_stack_machine_core.sv
// p-code stack machine core: one instruction per input beat, one result beat
// after reset a clearing pass writes zero to all StackDepth stack words
// steps: S_IDLE accepts, S_WALK/S_WWT walk each static link, S_RDA reads, S_EXE executes
// a call adds frame writes in S_WR2/S_WR3, a division runs a bit-serial divider in S_DIV
// S_OUT sends the result; one instruction in flight on a single ram port pair
// rst clears pc, stack top, frame base and control state
module pcode_stack_machine_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [2:0]               cmd,
  input  logic [3:0]               level,
  input  logic signed [31:0]       operand,
  input  logic signed [31:0]       read_value,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [psm_pkg::PcW-1:0]  next_pc,
  output logic                     halted,
  output logic                     print_valid,
  output logic signed [31:0]       print_value,
  output logic                     newline,
  output logic [2:0]               error
);
  import psm_pkg::*;
`include "assert_macros.svh"

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_WWT  = 4'd3;
  localparam logic [3:0] S_RDA  = 4'd4;
  localparam logic [3:0] S_RDB  = 4'd5;
  localparam logic [3:0] S_EXE  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WR2  = 4'd8;
  localparam logic [3:0] S_WR3  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_RDW  = 4'd11;

  logic [3:0] state;
  logic [PcW-1:0] pc;
  logic [TopW-1:0] stack_top;
  logic [SaW-1:0] frame_base;
  logic [SaW:0] clr_cnt;
  logic [SaW-1:0] old_fb;

  logic [2:0] i_cmd;
  logic [3:0] i_lev;
  logic [31:0] i_op;
  logic [31:0] i_rd;
  logic [SaW-1:0] base;
  logic [31:0] va;
  logic [31:0] vb;
  logic [1:0] rd_phase;

  logic [5:0] div_cnt;
  logic [31:0] div_q;
  logic [32:0] div_r;
  logic [31:0] div_d;
  logic div_neg;

  logic we;
  logic [SaW-1:0] waddr;
  logic [31:0] wdata;
  logic [SaW-1:0] raddr;
  logic [31:0] rdata;

  psm_ram #(.Width(32), .Depth(StackDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [PcW-1:0] seq;
  logic [PcW-1:0] tgt;
  logic [3:0] sub;
  logic opr_ok;
  logic [TopW:0] t_ext;
  logic [33:0] lod_addr;
  logic [33:0] int_addr;
  logic [32:0] link_s;
  logic [31:0] mul_r;

  assign seq = pc + PcW'(1);
  assign tgt = i_op[PcW-1:0];
  assign sub = i_op[3:0];
  assign opr_ok = (i_op[31:4] == '0) && (i_op[3:0] != 4'd15);
  assign t_ext = {1'b0, stack_top};
  assign lod_addr = {{2{i_op[31]}}, i_op} + 34'(base);
  assign int_addr = 34'(stack_top) + {{2{i_op[31]}}, i_op};
  assign link_s = {rdata[31], rdata};
  assign mul_r = va * vb;

  logic lod_ok;
  assign lod_ok = !lod_addr[33] && (lod_addr < 34'(StackDepth));

  logic [32:0] div_sub;
  assign div_sub = {div_r[31:0], div_q[31]} - {1'b0, div_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      pc <= '0;
      stack_top <= '0;
      frame_base <= '0;
      clr_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SaW+1)'(StackDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && !cmd_stall) begin
            i_cmd <= cmd;
            i_lev <= level;
            i_op <= operand;
            i_rd <= read_value;
            base <= frame_base;
            rd_phase <= 2'd0;
            print_valid <= 1'b0;
            print_value <= '0;
            newline <= 1'b0;
            error <= ERR_NONE;
            next_pc <= seq;
            if ((cmd == CMD_LOD || cmd == CMD_STO || cmd == CMD_CAL) && level != 4'd0)
              state <= S_WALK;
            else
              state <= S_RDA;
          end
        end
        S_WALK: state <= S_WWT;
        S_WWT: begin
          if (link_s[32] || link_s >= 33'(StackDepth)) begin
            error <= ERR_RANGE;
            state <= S_OUT;
          end else begin
            base <= rdata[SaW-1:0];
            i_lev <= i_lev - 4'd1;
            state <= (i_lev == 4'd1) ? S_RDA : S_WALK;
          end
        end
        S_RDA: begin
          rd_phase <= rd_phase + 2'd1;
          if (rd_phase == 2'd1) va <= rdata;
          if (rd_phase == 2'd2) begin
            vb <= rdata;
            state <= S_EXE;
          end
        end
        S_EXE: begin
          state <= S_OUT;
          unique case (i_cmd)
            CMD_LIT: begin
              if (stack_top >= TopW'(StackDepth)) error <= ERR_RANGE;
              else stack_top <= stack_top + 1'b1;
            end
            CMD_LOD: begin
              if (stack_top >= TopW'(StackDepth) || !lod_ok) error <= ERR_RANGE;
              else stack_top <= stack_top + 1'b1;
            end
            CMD_STO: begin
              if (stack_top == '0 || !lod_ok) error <= ERR_RANGE;
              else stack_top <= stack_top - 1'b1;
            end
            CMD_CAL: begin
              if (t_ext + (TopW+1)'(2) >= (TopW+1)'(StackDepth)) error <= ERR_RANGE;
              else begin
                frame_base <= stack_top[SaW-1:0];
                next_pc <= tgt;
                state <= S_WR2;
              end
            end
            CMD_INT: begin
              if (int_addr[33] || int_addr > 34'(StackDepth)) error <= ERR_RANGE;
              else stack_top <= int_addr[TopW-1:0];
            end
            CMD_JMP: next_pc <= tgt;
            CMD_JPC: begin
              if (stack_top == '0) error <= ERR_RANGE;
              else if (vb == '0) next_pc <= tgt;
            end
            default: begin
              if (!opr_ok) error <= ERR_OPR;
              else if (sub == OPR_RET) begin
                if (32'(frame_base) + 32'd2 >= 32'(StackDepth) || va[31]
                    || va >= 32'(StackDepth)) error <= ERR_RANGE;
                else begin
                  next_pc <= vb[PcW-1:0];
                  stack_top <= TopW'(frame_base);
                  frame_base <= va[SaW-1:0];
                end
              end else if (sub == OPR_NEG || sub == OPR_PRT) begin
                if (stack_top == '0) error <= ERR_RANGE;
                else if (sub == OPR_PRT) begin
                  print_valid <= 1'b1;
                  print_value <= vb;
                end
              end else if (sub == OPR_NL) newline <= 1'b1;
              else if (sub == OPR_RD) begin
                if (stack_top >= TopW'(StackDepth)) error <= ERR_RANGE;
                else stack_top <= stack_top + 1'b1;
              end else begin
                if (stack_top < TopW'(2)) error <= ERR_RANGE;
                else if (sub == OPR_DIV) begin
                  if (vb == '0) error <= ERR_DIV;
                  else begin
                    div_neg <= va[31] ^ vb[31];
                    div_q <= va[31] ? -va : va;
                    div_d <= vb[31] ? -vb : vb;
                    div_r <= '0;
                    div_cnt <= '0;
                    state <= S_DIV;
                  end
                end else stack_top <= stack_top - 1'b1;
              end
            end
          endcase
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_sub[32]) begin
            div_r <= {div_r[31:0], div_q[31]};
            div_q <= {div_q[30:0], 1'b0};
          end else begin
            div_r <= div_sub;
            div_q <= {div_q[30:0], 1'b1};
          end
          if (div_cnt == 6'd31) begin
            stack_top <= stack_top - 1'b1;
            state <= S_RDW;
          end
        end
        S_RDW: begin
          va <= div_neg ? -div_q : div_q;
          state <= S_OUT;
        end
        S_WR2: state <= S_WR3;
        S_WR3: state <= S_OUT;
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            pc <= next_pc;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (res_valid && !res_stall && !(state == S_OUT)) res_valid <= 1'b0;
    end
  end

  assign halted = (next_pc == '0);
  assign cmd_stall = (state != S_IDLE) || (res_valid && res_stall);

  // read address: phase 0 selects first operand, phase 1 the second
  logic [SaW-1:0] tm1;
  logic [SaW-1:0] tm2;
  assign tm1 = SaW'(stack_top - 1'b1);
  assign tm2 = SaW'(stack_top - TopW'(2));

  always_comb begin
    raddr = base;
    if (state == S_RDA) begin
      if (i_cmd == CMD_OPR && sub == OPR_RET)
        raddr = (rd_phase == 2'd0) ? SaW'(frame_base + SaW'(1)) : SaW'(frame_base + SaW'(2));
      else if (i_cmd == CMD_LOD)
        raddr = (rd_phase == 2'd0) ? lod_addr[SaW-1:0] : lod_addr[SaW-1:0];
      else
        raddr = (rd_phase == 2'd0) ? tm2 : tm1;
    end
  end

  // write port
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = clr_cnt[SaW-1:0];
    end else if (state == S_EXE) begin
      unique case (i_cmd)
        CMD_LIT: begin
          we = stack_top < TopW'(StackDepth);
          waddr = stack_top[SaW-1:0];
          wdata = i_op;
        end
        CMD_LOD: begin
          we = stack_top < TopW'(StackDepth) && lod_ok;
          waddr = stack_top[SaW-1:0];
          wdata = vb;
        end
        CMD_STO: begin
          we = stack_top != '0 && lod_ok;
          waddr = lod_addr[SaW-1:0];
          wdata = vb;
        end
        CMD_CAL: begin
          we = t_ext + (TopW+1)'(2) < (TopW+1)'(StackDepth);
          waddr = stack_top[SaW-1:0];
          wdata = 32'(base);
        end
        CMD_OPR: begin
          if (opr_ok && sub == OPR_NEG) begin
            we = stack_top != '0;
            waddr = tm1;
            wdata = -vb;
          end else if (opr_ok && sub == OPR_RD) begin
            we = stack_top < TopW'(StackDepth);
            waddr = stack_top[SaW-1:0];
            wdata = i_rd;
          end else if (opr_ok && sub >= OPR_ADD && sub <= OPR_LE && sub != OPR_DIV) begin
            we = stack_top >= TopW'(2);
            waddr = tm2;
            unique case (sub)
              OPR_ADD: wdata = va + vb;
              OPR_SUB: wdata = va - vb;
              OPR_MUL: wdata = mul_r;
              OPR_EQ:  wdata = 32'(va == vb);
              OPR_NE:  wdata = 32'(va != vb);
              OPR_LT:  wdata = 32'($signed(va) < $signed(vb));
              OPR_GE:  wdata = 32'(!($signed(va) < $signed(vb)));
              OPR_GT:  wdata = 32'($signed(vb) < $signed(va));
              default: wdata = 32'(!($signed(vb) < $signed(va)));
            endcase
          end
        end
        default: we = 1'b0;
      endcase
    end else if (state == S_WR2) begin
      we = 1'b1;
      waddr = SaW'(frame_base + SaW'(1));
      wdata = 32'(old_fb);
    end else if (state == S_WR3) begin
      we = 1'b1;
      waddr = SaW'(frame_base + SaW'(2));
      wdata = 32'(seq);
    end else if (state == S_RDW) begin
      we = 1'b1;
      waddr = tm1;
      wdata = div_neg ? -div_q : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) old_fb <= frame_base;
  end

  `CHK_IMPL(a_no_accept_busy, state != S_IDLE, cmd_stall)
  `CHK_IMPL(a_stack_bound, 1'b1, stack_top <= TopW'(StackDepth))
  `CHK_NEXT(a_halt_pc, res_valid && !res_stall && state == S_IDLE && halted, pc == '0)
endmodule
